>>> rtl/core/three_axis_window_min_max_defines.svh
// Assertion macros for the checker file of the window min/max block.
`ifndef THREE_AXIS_WINDOW_MIN_MAX_DEFINES_SVH
`define THREE_AXIS_WINDOW_MIN_MAX_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TAWMM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TAWMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tawmm_pkg.sv
package tawmm_pkg;

	localparam int MAX_WINDOW  = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int AXES        = 3;
	localparam int ADDR_BITS   = $clog2(MAX_WINDOW);
	localparam int LEN_BITS    = 7;

	localparam logic [LEN_BITS-1:0] RESET_LEN = LEN_BITS'(16);

	localparam int AXIS_X = 0;
	localparam int AXIS_Y = 1;
	localparam int AXIS_Z = 2;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef sample_t [AXES-1:0] entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;      // sample beat accepted: write it and restart the scan
		logic cfg_write;  // window length beat accepted
		logic wrap_step;  // subtract the window length from the write pointer once
		logic rd_en;      // read the entry at the scan address
		logic load_out;   // move the finished bounds into the result register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic wrap_pending; // write pointer not yet below the window length
		logic scan_last;    // scan address is the last entry of the window
	} status_t;

	// Window length as used: zero counts as one, large values saturate.
	function automatic logic [LEN_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] len);
		logic [LEN_BITS-1:0] n;
		n = len;
		if (len == '0) begin
			n = LEN_BITS'(1);
		end else if (len > LEN_BITS'(MAX_WINDOW)) begin
			n = LEN_BITS'(MAX_WINDOW);
		end
		return n;
	endfunction

endpackage

>>> rtl/core/three_axis_window_min_max.sv
// Sliding-window minimum and maximum of three-axis samples. Each sample beat
// is written into a 64-entry ring store at the write pointer, then entries 0
// to n-1 are read one per cycle through the single read port of the store,
// and the smallest and largest value of each axis leave as one result beat.
// Here n is window_length, with zero taken as one and values above 64 taken
// as 64. After acceptance a sample passes the states SCAN, DRAIN and DONE,
// and no new sample is taken until its result is loaded; a finished result
// waits in an output register, so the next sample is taken while it is
// still pending. The load waits while an earlier result is not yet taken.
// Entries never written read as zero. Writing window_length zeroes the
// entries at and beyond the new length at once, then the write pointer is
// reduced by repeated subtraction, during which neither samples nor further
// length writes are taken. A length write that is offered goes ahead of a
// waiting sample.
module three_axis_window_min_max (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic        [tawmm_pkg::LEN_BITS-1:0]  window_length,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [tawmm_pkg::SAMPLE_BITS-1:0] sample_x,
	input  logic signed [tawmm_pkg::SAMPLE_BITS-1:0] sample_y,
	input  logic signed [tawmm_pkg::SAMPLE_BITS-1:0] sample_z,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [tawmm_pkg::SAMPLE_BITS-1:0] min_x,
	output logic signed [tawmm_pkg::SAMPLE_BITS-1:0] min_y,
	output logic signed [tawmm_pkg::SAMPLE_BITS-1:0] min_z,
	output logic signed [tawmm_pkg::SAMPLE_BITS-1:0] max_x,
	output logic signed [tawmm_pkg::SAMPLE_BITS-1:0] max_y,
	output logic signed [tawmm_pkg::SAMPLE_BITS-1:0] max_z
);

	tawmm_pkg::cmd_t    cmd;
	tawmm_pkg::status_t stat;
	tawmm_pkg::entry_t  sample_in;
	tawmm_pkg::entry_t  res_lo;
	tawmm_pkg::entry_t  res_hi;

	// Pack the three axes of the input beat.
	always_comb begin
		sample_in                   = '0;
		sample_in[tawmm_pkg::AXIS_X] = sample_x;
		sample_in[tawmm_pkg::AXIS_Y] = sample_y;
		sample_in[tawmm_pkg::AXIS_Z] = sample_z;
	end

	tawmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tawmm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.window_length (window_length),
		.sample_in     (sample_in),
		.res_lo        (res_lo),
		.res_hi        (res_hi)
	);

	// Unpack the result beat.
	assign min_x = res_lo[tawmm_pkg::AXIS_X];
	assign min_y = res_lo[tawmm_pkg::AXIS_Y];
	assign min_z = res_lo[tawmm_pkg::AXIS_Z];
	assign max_x = res_hi[tawmm_pkg::AXIS_X];
	assign max_y = res_hi[tawmm_pkg::AXIS_Y];
	assign max_z = res_hi[tawmm_pkg::AXIS_Z];

endmodule

>>> rtl/core/tawmm_ctrl.sv
module tawmm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  tawmm_pkg::status_t stat,
	output tawmm_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	// Handshakes are open only when idle with the pointer already wrapped.
	// A waiting length write goes before a sample, so both never land together.
	assign in_ready  = (state_q == ST_IDLE) && !stat.wrap_pending && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE) && !stat.wrap_pending;
	assign out_valid = out_valid_q;

	// Commands to the datapath.
	always_comb begin
		cmd           = '0;
		cmd.start     = in_valid && in_ready;
		cmd.cfg_write = cfg_valid && cfg_ready;
		cmd.wrap_step = (state_q == ST_IDLE) && stat.wrap_pending;
		cmd.rd_en     = (state_q == ST_SCAN);
		cmd.load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.start) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.scan_last) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (cmd.load_out) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State and result-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/tawmm_dp.sv
module tawmm_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tawmm_pkg::cmd_t                     cmd,
	output tawmm_pkg::status_t                  stat,
	input  logic [tawmm_pkg::LEN_BITS-1:0]      window_length,
	input  tawmm_pkg::entry_t                   sample_in,
	output tawmm_pkg::entry_t                   res_lo,
	output tawmm_pkg::entry_t                   res_hi
);

	logic [tawmm_pkg::LEN_BITS-1:0]   len_q;
	logic [tawmm_pkg::LEN_BITS-1:0]   n_eff;
	logic [tawmm_pkg::LEN_BITS-1:0]   n_new;
	logic [tawmm_pkg::ADDR_BITS-1:0]  wp_q;
	logic [tawmm_pkg::ADDR_BITS-1:0]  scan_q;
	logic [tawmm_pkg::MAX_WINDOW-1:0] valid_q;
	logic [tawmm_pkg::MAX_WINDOW-1:0] keep_mask;
	logic                             wp_at_end;

	tawmm_pkg::entry_t mem_q [tawmm_pkg::MAX_WINDOW];
	tawmm_pkg::entry_t rd_data_s1;
	logic              rd_valid_s1;
	logic              rd_en_s1;
	logic              first_s1;
	tawmm_pkg::entry_t val_s1;
	tawmm_pkg::entry_t lo_q;
	tawmm_pkg::entry_t hi_q;
	tawmm_pkg::entry_t lo_nxt;
	tawmm_pkg::entry_t hi_nxt;
	tawmm_pkg::entry_t res_lo_q;
	tawmm_pkg::entry_t res_hi_q;

	assign n_eff = tawmm_pkg::eff_len(len_q);
	assign n_new = tawmm_pkg::eff_len(window_length);

	// Status toward the controller.
	assign stat.wrap_pending = {1'b0, wp_q} >= n_eff;
	assign stat.scan_last    = {1'b0, scan_q} == (n_eff - tawmm_pkg::LEN_BITS'(1));

	assign wp_at_end = ({1'b0, wp_q} + tawmm_pkg::LEN_BITS'(1)) == n_eff;

	// Entries at and beyond a new window length are dropped back to zero.
	always_comb begin
		for (int i = 0; i < tawmm_pkg::MAX_WINDOW; i++) begin
			keep_mask[i] = tawmm_pkg::LEN_BITS'(i) < n_new;
		end
	end

	// Window length, write pointer, scan address and entry valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= tawmm_pkg::RESET_LEN;
			wp_q    <= '0;
			scan_q  <= '0;
			valid_q <= '0;
		end else begin
			if (cmd.cfg_write) begin
				len_q   <= window_length;
				valid_q <= valid_q & keep_mask;
			end
			if (cmd.wrap_step) begin
				wp_q <= wp_q - n_eff[tawmm_pkg::ADDR_BITS-1:0];
			end
			if (cmd.start) begin
				valid_q[wp_q] <= 1'b1;
				wp_q          <= wp_at_end ? '0 : wp_q + tawmm_pkg::ADDR_BITS'(1);
				scan_q        <= '0;
			end else if (cmd.rd_en) begin
				scan_q <= scan_q + tawmm_pkg::ADDR_BITS'(1);
			end
		end
	end

	// Sample store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mem_q[wp_q] <= sample_in;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem_q[scan_q];
		end
	end

	// Read stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_en_s1    <= 1'b0;
			first_s1    <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_en_s1    <= cmd.rd_en;
			first_s1    <= cmd.rd_en && (scan_q == '0);
			rd_valid_s1 <= valid_q[scan_q];
		end
	end

	// An entry never written since reset or a clear reads as zero.
	assign val_s1 = rd_valid_s1 ? rd_data_s1 : '0;

	// Independent min and max per axis.
	always_comb begin
		for (int a = 0; a < tawmm_pkg::AXES; a++) begin
			if (first_s1 || ($signed(val_s1[a]) < $signed(lo_q[a]))) begin
				lo_nxt[a] = val_s1[a];
			end else begin
				lo_nxt[a] = lo_q[a];
			end
			if (first_s1 || ($signed(val_s1[a]) > $signed(hi_q[a]))) begin
				hi_nxt[a] = val_s1[a];
			end else begin
				hi_nxt[a] = hi_q[a];
			end
		end
	end

	// Running bounds and the result register.
	always_ff @(posedge clk) begin
		if (rd_en_s1) begin
			lo_q <= lo_nxt;
			hi_q <= hi_nxt;
		end
		if (cmd.load_out) begin
			res_lo_q <= lo_q;
			res_hi_q <= hi_q;
		end
	end

	assign res_lo = res_lo_q;
	assign res_hi = res_hi_q;

endmodule

>>> rtl/core/tawmm_checker.sv
`include "three_axis_window_min_max_defines.svh"

module tawmm_checker (
	input logic                                     clk,
	input logic                                     arst_n,
	input logic                                     in_valid,
	input logic                                     in_ready,
	input logic                                     out_valid,
	input logic                                     out_ready,
	input logic signed [tawmm_pkg::SAMPLE_BITS-1:0] min_x,
	input logic signed [tawmm_pkg::SAMPLE_BITS-1:0] min_y,
	input logic signed [tawmm_pkg::SAMPLE_BITS-1:0] min_z,
	input logic signed [tawmm_pkg::SAMPLE_BITS-1:0] max_x,
	input logic signed [tawmm_pkg::SAMPLE_BITS-1:0] max_y,
	input logic signed [tawmm_pkg::SAMPLE_BITS-1:0] max_z
);

	// A result beat that is not taken stays offered.
	`TAWMM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result beat dropped while stalled")

	// A stalled result beat keeps its bounds.
	`TAWMM_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable({min_x, min_y, min_z, max_x, max_y, max_z}), "result changed while stalled")

	// The scan of one sample keeps the input closed in the following cycle.
	`TAWMM_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "sample taken while a scan runs")

	// Every axis minimum lies at or below its maximum.
	`TAWMM_ASSERT_SAME(a_bounds_order, clk, arst_n, out_valid, (min_x <= max_x) && (min_y <= max_y) && (min_z <= max_z), "minimum above maximum")

endmodule

bind three_axis_window_min_max tawmm_checker u_tawmm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.min_x     (min_x),
	.min_y     (min_y),
	.min_z     (min_z),
	.max_x     (max_x),
	.max_y     (max_y),
	.max_z     (max_z)
);
